### rtl/rotated_window_framebuffer_top_macros.svh
// ---------------------------------------------------------------------------
// Rotated window frame buffer: assertion macros
// Assertions sample on clk and are disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ROTATED_WINDOW_FRAMEBUFFER_TOP_MACROS_SVH
`define ROTATED_WINDOW_FRAMEBUFFER_TOP_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define RWF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rotated window frame buffer: assertion failed");

// Next-cycle implication.
`define RWF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rotated window frame buffer: assertion failed");

`else

`define RWF_ASSERT_IMP(lbl, ante, cons)
`define RWF_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

### rtl/rwf_pkg.sv
// ---------------------------------------------------------------------------
// rwf_pkg
// Types and codes shared by the rotated window frame buffer modules.
// ---------------------------------------------------------------------------
`default_nettype none

package rwf_pkg;

    // Command codes carried in a request word.
    localparam logic [1:0] CMD_START_WRITE = 2'd0;
    localparam logic [1:0] CMD_WRITE_PIXEL = 2'd1;
    localparam logic [1:0] CMD_START_READ  = 2'd2;
    localparam logic [1:0] CMD_READ_PIXEL  = 2'd3;

    // Orientation codes.
    localparam logic [1:0] ORIENT_0   = 2'd0;
    localparam logic [1:0] ORIENT_90  = 2'd1;
    localparam logic [1:0] ORIENT_180 = 2'd2;
    localparam logic [1:0] ORIENT_270 = 2'd3;

    // Register indexes on the configuration port.
    localparam logic REG_ORIENTATION = 1'b0;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  win_x;
        logic [7:0]  win_y;
        logic [7:0]  win_width;
        logic [7:0]  win_height;
        logic [15:0] pixel_in;
    } rwf_req_t;

    typedef struct packed {
        logic [15:0] pixel_out;
        logic        out_of_range;
    } rwf_rsp_t;

    // Window origin and size as latched by a start command.
    typedef struct packed {
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] width;
        logic [7:0] height;
    } rwf_win_t;

    // Logical cursor position.
    typedef struct packed {
        logic [7:0] col;
        logic [7:0] row;
    } rwf_pos_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_READY,
        ST_FETCH
    } rwf_state_t;

endpackage

`default_nettype wire

### rtl/rotated_window_framebuffer_top.sv
// Reads: a read pixel word goes through the registered read of the single
// memory port and the ST_FETCH state into the result register that drives rsp.
// Start and write pixel words are taken one per cycle while no read word waits
// on rsp; a read pixel word holds off new requests while ST_FETCH passes it on.
// Reset: cursors and orientation go to zero, then a clearing pass over all
// SCREEN_WIDTH*SCREEN_HEIGHT entries zeroes the store while req_ready is low.
// ---------------------------------------------------------------------------
// rotated_window_framebuffer_top
// RGB565 frame store with rotated window write and read cursors.
// ---------------------------------------------------------------------------
`default_nettype none
`include "rotated_window_framebuffer_top_macros.svh"

module rotated_window_framebuffer_top #(
    parameter int SCREEN_WIDTH  = 135,
    parameter int SCREEN_HEIGHT = 240
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire rwf_pkg::rwf_req_t req,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output rwf_pkg::rwf_rsp_t      rsp,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);
    import rwf_pkg::*;

    localparam int DEPTH  = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    rwf_state_t        state_reg;
    rwf_state_t        state_next;
    logic [1:0]        orientation_reg;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    rwf_rsp_t          rsp_data_reg;
    logic              oor_reg;
    logic              accept;
    logic              cmd_is_read;
    logic              wr_start;
    logic              wr_adv;
    logic              rd_start;
    logic              rd_adv;
    rwf_win_t          start_win;
    rwf_pos_t          wr_pos;
    rwf_pos_t          rd_pos;
    rwf_pos_t          map_pos;
    logic [ADDR_W-1:0] map_addr;
    logic              map_in_range;
    logic              mem_wr_en;
    logic              mem_rd_en;
    logic [15:0]       mem_rd_data;
    logic              store_busy;

    // Configuration port.
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orientation_reg <= ORIENT_0;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_ORIENTATION))
        begin
            orientation_reg <= pwdata[1:0];
        end
    end

    assign prdata = (paddr[2] == REG_ORIENTATION) ? {30'd0, orientation_reg} : 32'd0;

    // Request decode.
    assign accept      = req_valid && req_ready;
    assign cmd_is_read = (req.cmd == CMD_READ_PIXEL);
    assign wr_start    = accept && (req.cmd == CMD_START_WRITE);
    assign wr_adv      = accept && (req.cmd == CMD_WRITE_PIXEL);
    assign rd_start    = accept && (req.cmd == CMD_START_READ);
    assign rd_adv      = accept && cmd_is_read;

    assign start_win.x      = req.win_x;
    assign start_win.y      = req.win_y;
    assign start_win.width  = req.win_width;
    assign start_win.height = req.win_height;

    rwf_cursor u_wr_cursor (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (wr_start),
        .advance   (wr_adv),
        .start_win (start_win),
        .pos       (wr_pos)
    );

    rwf_cursor u_rd_cursor (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rd_start),
        .advance   (rd_adv),
        .start_win (start_win),
        .pos       (rd_pos)
    );

    assign map_pos = cmd_is_read ? rd_pos : wr_pos;

    rwf_addr_map #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .ADDR_W        (ADDR_W)
    ) u_addr_map (
        .orientation (orientation_reg),
        .pos         (map_pos),
        .addr        (map_addr),
        .in_range    (map_in_range)
    );

    // Off-screen writes are dropped; off-screen reads skip the memory.
    assign mem_wr_en = wr_adv && map_in_range;
    assign mem_rd_en = rd_adv && map_in_range;

    rwf_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mem_wr_en),
        .rd_en   (mem_rd_en),
        .addr    (map_addr),
        .wr_data (req.pixel_in),
        .rd_data (mem_rd_data),
        .busy    (store_busy)
    );

    // Sequencer. A read is accepted only when the result register will be
    // free, so the fetched word always has somewhere to go.
    always_comb
    begin
        state_next     = state_reg;
        req_ready      = 1'b0;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        case (state_reg)
            ST_CLEAR:
            begin
                if (!store_busy)
                begin
                    state_next = ST_READY;
                end
            end
            ST_READY:
            begin
                req_ready = !rsp_valid_reg || rsp_ready;
                if (req_valid && req_ready && cmd_is_read)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                rsp_valid_next = 1'b1;
                state_next     = ST_READY;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_adv)
        begin
            oor_reg <= !map_in_range;
        end
        if (state_reg == ST_FETCH)
        begin
            rsp_data_reg.pixel_out    <= oor_reg ? 16'd0 : mem_rd_data;
            rsp_data_reg.out_of_range <= oor_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_data_reg;

    `RWF_ASSERT_IMP(a_no_req_while_clearing, store_busy, !req_ready)
    `RWF_ASSERT_NXT(a_read_goes_to_fetch, rd_adv, state_reg == ST_FETCH)
    `RWF_ASSERT_IMP(a_fetch_slot_free, state_reg == ST_FETCH, !rsp_valid_reg)
    `RWF_ASSERT_NXT(a_fetch_fills_result, state_reg == ST_FETCH, rsp_valid_reg)
    `RWF_ASSERT_IMP(a_oor_reads_zero, rsp_valid_reg && rsp_data_reg.out_of_range,
                    rsp_data_reg.pixel_out == 16'd0)

endmodule

`default_nettype wire

### rtl/rwf_store.sv
// ---------------------------------------------------------------------------
// rwf_store
// Single-port pixel memory with a registered read and a clearing sweep
// that zeroes every entry after reset.
// ---------------------------------------------------------------------------
`default_nettype none
`include "rotated_window_framebuffer_top_macros.svh"

module rwf_store #(
    parameter int DEPTH  = 32400,
    parameter int ADDR_W = 15
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [15:0]       wr_data,
    output logic      [15:0]       rd_data,
    output logic                   busy
);
    import rwf_pkg::*;

    logic [15:0]       mem [DEPTH];
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [ADDR_W-1:0] clr_cnt_next;
    logic              clr_active_reg;
    logic              clr_active_next;
    logic [15:0]       rd_data_reg;

    always_comb
    begin
        clr_cnt_next    = clr_cnt_reg;
        clr_active_next = clr_active_reg;
        if (clr_active_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
            begin
                clr_active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg    <= '0;
            clr_active_reg <= 1'b1;
        end
        else
        begin
            clr_cnt_reg    <= clr_cnt_next;
            clr_active_reg <= clr_active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_active_reg;

    // The sweep owns the memory port until it has finished.
    `RWF_ASSERT_IMP(a_no_access_in_clear, clr_active_reg, !wr_en && !rd_en)
    `RWF_ASSERT_NXT(a_clear_ends_at_last, clr_active_reg && (clr_cnt_reg == ADDR_W'(DEPTH - 1)),
                    !clr_active_reg)
    `RWF_ASSERT_NXT(a_clear_idle_no_count, !clr_active_reg, $stable(clr_cnt_reg))

endmodule

`default_nettype wire

### rtl/rwf_cursor.sv
// ---------------------------------------------------------------------------
// rwf_cursor
// Window cursor: latches a window on start and walks it row by row,
// wrapping to the origin after the last row.
// ---------------------------------------------------------------------------
`default_nettype none

module rwf_cursor (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               advance,
    input  wire rwf_pkg::rwf_win_t  start_win,
    output rwf_pkg::rwf_pos_t       pos
);
    import rwf_pkg::*;

    rwf_win_t   origin_reg;
    rwf_win_t   origin_next;
    rwf_pos_t   pos_reg;
    rwf_pos_t   pos_next;
    logic [7:0] cols_left_reg;
    logic [7:0] cols_left_next;
    logic [7:0] rows_left_reg;
    logic [7:0] rows_left_next;

    always_comb
    begin
        origin_next    = origin_reg;
        pos_next       = pos_reg;
        cols_left_next = cols_left_reg;
        rows_left_next = rows_left_reg;
        if (start)
        begin
            origin_next    = start_win;
            pos_next.col   = start_win.x;
            pos_next.row   = start_win.y;
            cols_left_next = start_win.width;
            rows_left_next = start_win.height;
        end
        else if (advance)
        begin
            pos_next.col   = pos_reg.col + 8'd1;
            cols_left_next = cols_left_reg - 8'd1;
            // A count of zero means 256, so only a count of one ends the row.
            if (cols_left_reg == 8'd1)
            begin
                pos_next.col   = origin_reg.x;
                cols_left_next = origin_reg.width;
                pos_next.row   = pos_reg.row + 8'd1;
                rows_left_next = rows_left_reg - 8'd1;
                if (rows_left_reg == 8'd1)
                begin
                    pos_next.row   = origin_reg.y;
                    rows_left_next = origin_reg.height;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg    <= '0;
            pos_reg       <= '0;
            cols_left_reg <= '0;
            rows_left_reg <= '0;
        end
        else
        begin
            origin_reg    <= origin_next;
            pos_reg       <= pos_next;
            cols_left_reg <= cols_left_next;
            rows_left_reg <= rows_left_next;
        end
    end

    assign pos = pos_reg;

endmodule

`default_nettype wire

### rtl/rwf_addr_map.sv
// ---------------------------------------------------------------------------
// rwf_addr_map
// Maps a logical cursor position through the selected rotation to a
// physical row-major address, and flags positions off the logical screen.
// ---------------------------------------------------------------------------
`default_nettype none

module rwf_addr_map #(
    parameter int SCREEN_WIDTH  = 135,
    parameter int SCREEN_HEIGHT = 240,
    parameter int ADDR_W        = 15
) (
    input  wire logic [1:0]        orientation,
    input  wire rwf_pkg::rwf_pos_t pos,
    output logic [ADDR_W-1:0]      addr,
    output logic                   in_range
);
    import rwf_pkg::*;

    localparam logic [7:0] SW8 = 8'(SCREEN_WIDTH);
    localparam logic [7:0] SH8 = 8'(SCREEN_HEIGHT);

    logic [7:0]  lw;
    logic [7:0]  lh;
    logic [7:0]  phys_row;
    logic [7:0]  phys_col;
    logic [16:0] row_base;
    logic [16:0] lin_addr;

    always_comb
    begin
        // Quarter turns swap the logical width and height.
        lw = orientation[0] ? SH8 : SW8;
        lh = orientation[0] ? SW8 : SH8;
        case (orientation)
            ORIENT_0:
            begin
                phys_row = pos.row;
                phys_col = pos.col;
            end
            ORIENT_90:
            begin
                phys_row = SH8 - 8'd1 - pos.col;
                phys_col = pos.row;
            end
            ORIENT_180:
            begin
                phys_row = SH8 - 8'd1 - pos.row;
                phys_col = SW8 - 8'd1 - pos.col;
            end
            ORIENT_270:
            begin
                phys_row = pos.col;
                phys_col = SW8 - 8'd1 - pos.row;
            end
            default:
            begin
                phys_row = pos.row;
                phys_col = pos.col;
            end
        endcase
        row_base = 17'(phys_row) * 17'(SCREEN_WIDTH);
        lin_addr = row_base + 17'(phys_col);
    end

    assign in_range = (pos.col < lw) && (pos.row < lh);
    assign addr     = lin_addr[ADDR_W-1:0];

endmodule

`default_nettype wire
